[hw/rtl/sv_sup_pkg.sv]
// sv_sup_pkg: shared constants and arithmetic helpers of the sampled-values
// unpack/scale block. No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package sv_sup_pkg;

  // record layout
  localparam int unsigned Channels  = 8;
  localparam int unsigned CodeBits  = 18;
  localparam int unsigned FieldBits = 48;
  localparam int unsigned RecBits   = 3 * FieldBits;

  // frame sizing
  localparam int unsigned MaxAsdu     = 8;
  localparam int unsigned ResultLimit = 8;
  localparam int unsigned FrameMax    = (MaxAsdu < ResultLimit) ? MaxAsdu : ResultLimit;

  // sample counter, wraps at 4000
  localparam logic [11:0] CountMax   = 12'd3999;
  localparam logic [11:0] CountReset = 12'd3999;

  // scaling: code * 500000 / (2^17 - 1)
  localparam int unsigned ProdBits = 36;
  localparam int unsigned ValBits  = 20;
  localparam logic [18:0] ScaleNum = 19'd500000;
  localparam logic [17:0] ScaleDen = 18'h1ffff;

  typedef logic signed [ValBits-1:0] val_t;

  // saturate the configured frame length
  function automatic logic [3:0] frame_len(input logic [3:0] cfg);
    logic [3:0] lim;
    lim = 4'(FrameMax);
    frame_len = (cfg > lim) ? lim : cfg;
  endfunction

  // next sample count, modulo 4000
  function automatic logic [11:0] count_inc(input logic [11:0] cnt);
    count_inc = (cnt == CountMax) ? 12'd0 : cnt + 12'd1;
  endfunction

  // exact floor(p / (2^17 - 1)) by folding the high part twice
  function automatic logic [19:0] div_den(input logic [ProdBits-1:0] p);
    logic [18:0] hi;
    logic [19:0] t;
    logic [17:0] u;
    logic        corr;
    hi   = p[ProdBits-1:17];
    t    = {1'b0, hi} + {3'b0, p[16:0]};
    u    = {15'b0, t[19:17]} + {1'b0, t[16:0]};
    corr = (u >= ScaleDen);
    div_den = {1'b0, hi} + {17'b0, t[19:17]} + {19'b0, corr};
  endfunction

endpackage

[hw/rtl/sv_sample_unpack_scale.sv]
// sv_sample_unpack_scale: unpacks eight 18-bit ADC codes, scales them and emits
// one sampled-values word per ASDU with a running sample count. Uses sv_sup_pkg.
`timescale 1ns / 1ps

// One input word carries a tick of the sample clock and, when samples_present_i
// is set, an 18-byte ADC record of eight 18-bit two's-complement codes packed
// msb first (raw_bytes_first_i holds the leading bytes). Each code is scaled to
// code*500000/131071 truncated toward zero; the scaled values are held and
// reused on ticks without a record (zero after reset). Every tick then gives
// asdu_count results (saturated at 8, none for 0), one per cycle while
// out_ready_i is high, each with asdu_index_o from 0, sample_count_o running
// modulo 4000 from 0 after reset, the eight held values and last_of_frame_o on
// the final one. The input is registered, products are registered, and the
// result register follows. While a frame drains, up to two more input words
// wait in the input and product registers; after that in_ready_o stays low
// until the last result of the frame is taken (in_ready_o follows out_ready_i
// combinationally through the stage chain). A tick with n ASDUs holds the
// result register until its n results are taken. asdu_count_i is written
// through the cfg port (always ready) and must only change while the block is
// idle.
module sv_sample_unpack_scale
  import sv_sup_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           asdu_count_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 samples_present_i,
  input  logic [FieldBits-1:0] raw_bytes_first_i,
  input  logic [FieldBits-1:0] raw_bytes_middle_i,
  input  logic [FieldBits-1:0] raw_bytes_last_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           asdu_index_o,
  output logic [11:0]          sample_count_o,
  output logic signed [19:0]   chan_one_o,
  output logic signed [19:0]   chan_two_o,
  output logic signed [19:0]   chan_three_o,
  output logic signed [19:0]   chan_four_o,
  output logic signed [19:0]   chan_five_o,
  output logic signed [19:0]   chan_six_o,
  output logic signed [19:0]   chan_seven_o,
  output logic signed [19:0]   chan_eight_o,
  output logic                 last_of_frame_o
);

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [3:0] asdu_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asdu_cfg_q <= 4'd1;
    end else if (cfg_valid_i) begin
      asdu_cfg_q <= asdu_count_i;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake chain: stage a (input reg) -> stage b (products) -> result reg
  // ---------------------------------------------------------------------------
  logic               a_valid_q, a_present_q;
  logic [RecBits-1:0] a_rec_q;
  logic               b_valid_q, b_present_q;
  logic [ProdBits-1:0] b_prod_q [Channels];
  logic [Channels-1:0] b_neg_q;

  logic        out_valid_q, out_last_q;
  logic [2:0]  out_idx_q;
  logic [3:0]  frame_n_q;
  logic [11:0] cnt_q;     // last count handed out, also the shown sample count
  val_t        held_q [Channels];

  logic frame_more, slot_free, step_frame, b_take, b_ready, a_move, a_ready;

  // more results of the current tick still to come
  assign frame_more = out_valid_q && !out_last_q;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign step_frame = frame_more && out_ready_i;
  // a new tick enters only once the previous one has shown its last result
  assign b_take     = b_valid_q && slot_free && !frame_more;
  assign b_ready    = !b_valid_q || b_take;
  assign a_move     = a_valid_q && b_ready;
  assign a_ready    = !a_valid_q || a_move;
  assign in_ready_o = a_ready;

  // ---------------------------------------------------------------------------
  // stage a: capture the record
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_present_q <= samples_present_i;
      a_rec_q     <= {raw_bytes_first_i, raw_bytes_middle_i, raw_bytes_last_i};
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: per-channel unpack to sign/magnitude and multiply by 500000
  // ---------------------------------------------------------------------------
  logic [CodeBits-1:0] code   [Channels];
  logic [CodeBits-1:0] mag    [Channels];
  logic [ProdBits-1:0] prod_d [Channels];
  logic [Channels-1:0] neg_d;

  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      code[ch]   = a_rec_q[RecBits-1-CodeBits*ch -: CodeBits];
      neg_d[ch]  = code[ch][CodeBits-1];
      // magnitude of the most negative code is 2^17, which still fits unsigned
      mag[ch]    = neg_d[ch] ? (~code[ch] + 18'd1) : code[ch];
      // largest product 2^17 * 500000 stays below 2^36
      prod_d[ch] = {18'b0, mag[ch]} * {17'b0, ScaleNum};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_present_q <= a_present_q;
      b_neg_q     <= neg_d;
      for (int ch = 0; ch < Channels; ch++) begin
        b_prod_q[ch] <= prod_d[ch];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register: divide, apply sign, update held values, walk the frame
  // ---------------------------------------------------------------------------
  val_t        scaled [Channels];
  logic [19:0] quot   [Channels];
  logic [3:0]  n_new;

  always_comb begin
    for (int ch = 0; ch < Channels; ch++) begin
      quot[ch]   = div_den(b_prod_q[ch]);
      // truncation toward zero: divide the magnitude, then negate
      scaled[ch] = b_neg_q[ch] ? val_t'(-quot[ch]) : val_t'(quot[ch]);
    end
  end

  assign n_new = frame_len(asdu_cfg_q);

  logic        out_valid_d, out_last_d;
  logic [2:0]  out_idx_d;
  logic [3:0]  frame_n_d;
  logic [11:0] cnt_d;
  val_t        held_d [Channels];

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_last_d  = out_last_q;
    out_idx_d   = out_idx_q;
    frame_n_d   = frame_n_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    if (step_frame) begin
      // next ASDU of the same tick
      out_valid_d = 1'b1;
      out_idx_d   = out_idx_q + 3'd1;
      out_last_d  = ({1'b0, out_idx_q} + 4'd2 == frame_n_q);
      cnt_d       = count_inc(cnt_q);
    end else if (b_take) begin
      if (b_present_q) begin
        held_d = scaled;
      end
      // zero ASDUs: tick consumed, nothing shown, counter kept
      if (n_new != 4'd0) begin
        out_valid_d = 1'b1;
        out_idx_d   = 3'd0;
        out_last_d  = (n_new == 4'd1);
        frame_n_d   = n_new;
        cnt_d       = count_inc(cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= 3'd0;
      frame_n_q   <= 4'd0;
      cnt_q       <= CountReset;
      for (int ch = 0; ch < Channels; ch++) begin
        held_q[ch] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_idx_q   <= out_idx_d;
      frame_n_q   <= frame_n_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------------
  assign out_valid_o     = out_valid_q;
  assign asdu_index_o    = out_idx_q;
  assign sample_count_o  = cnt_q;
  assign last_of_frame_o = out_last_q;
  assign chan_one_o      = held_q[0];
  assign chan_two_o      = held_q[1];
  assign chan_three_o    = held_q[2];
  assign chan_four_o     = held_q[3];
  assign chan_five_o     = held_q[4];
  assign chan_six_o      = held_q[5];
  assign chan_seven_o    = held_q[6];
  assign chan_eight_o    = held_q[7];

endmodule

[hw/rtl/sv_sup_checker.sv]
// sv_sup_checker: port-level assertions for sv_sample_unpack_scale, with its bind.
// Depends on sv_sup_pkg and the top level's port list.
`timescale 1ns / 1ps

module sv_sup_checker
  import sv_sup_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [2:0]           asdu_index_o,
  input logic [11:0]          sample_count_o,
  input logic signed [19:0]   chan_one_o,
  input logic signed [19:0]   chan_eight_o,
  input logic                 last_of_frame_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_count_o)
      && $stable(asdu_index_o) && $stable(last_of_frame_o) && $stable(chan_one_o))
    else $error("result word changed while stalled");

  // counter stays in its modulo range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_count_o <= CountMax)
    else $error("sample count out of range");

  // within a tick the next ASDU follows at once with the next index and count
  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_frame_o |=> out_valid_o
      && asdu_index_o == 3'($past(asdu_index_o) + 3'd1)
      && sample_count_o == count_inc($past(sample_count_o))
      && $stable(chan_one_o) && $stable(chan_eight_o))
    else $error("frame sequence broken");

  // frame never runs past the saturated length
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && asdu_index_o == 3'(FrameMax - 1) |-> last_of_frame_o)
    else $error("frame longer than the limit");

endmodule

bind sv_sample_unpack_scale sv_sup_checker u_sv_sup_checker (.*);
